// ===== design/s2l_pkg.sv =====
package s2l_pkg;

	// default fraction bits of the internal fixed-point path
	localparam int FRAC_BITS_DEF = 16;
	// fraction bits used while building the gamma table
	localparam int GAM_BITS = 30;
	// entries of the per-channel gamma table
	localparam int LUT_DEPTH = 256;
	// fixed pipeline stages added to FRAC_BITS (3 front, 2 root wrap, 4 code)
	localparam int PIPE_FIXED = 9;

	// q to the fifth power, each product truncated to Q0.30
	function automatic longint unsigned pow5_g(input longint unsigned q);
		longint unsigned p;
		p = (q * q) >> GAM_BITS;
		p = (p * q) >> GAM_BITS;
		p = (p * q) >> GAM_BITS;
		p = (p * q) >> GAM_BITS;
		return p;
	endfunction

	// linear-light value of one 8-bit sample, evaluated at elaboration only
	function automatic longint unsigned lin_of(input longint unsigned c, input int frac);
		longint unsigned one;
		longint unsigned u;
		longint unsigned s;
		longint unsigned q;
		longint unsigned cand;
		longint unsigned lin30;
		longint unsigned res;
		int sh;
		one = 64'd1 << GAM_BITS;
		if (c <= 64'd10) begin
			res = (((c * 64'd100) << frac) + 64'd164730) / 64'd329460;
		end else begin
			u = (((c * 64'd1000 + 64'd14025) << GAM_BITS) + 64'd134512) / 64'd269025;
			s = (u * u + (one >> 1)) >> GAM_BITS;
			q = 64'd0;
			for (int b = GAM_BITS; b >= 0; b--) begin
				cand = q | (64'd1 << b);
				if (cand <= one && pow5_g(cand) <= s) begin
					q = cand;
				end
			end
			lin30 = (s * q) >> GAM_BITS;
			sh = GAM_BITS - frac;
			res = (lin30 + (64'd1 << (sh - 1))) >> sh;
		end
		return res;
	endfunction

endpackage

// ===== design/s2l_linmat.sv =====
module s2l_linmat #(
	parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	output logic [FRAC_BITS+1:0] t_x,
	output logic [FRAC_BITS+1:0] t_y,
	output logic [FRAC_BITS+1:0] t_z
);
	import s2l_pkg::*;

	localparam int W  = FRAC_BITS + 1;
	localparam int PW = 2 * W;
	localparam int SW = PW + 2;
	localparam int TW = FRAC_BITS + 2;

	// bradford d50 rows, already divided by the white point, Q1.F
	localparam longint unsigned CF [3][3] = '{
		'{((64'd4360747 << FRAC_BITS) + 64'd4821100) / 64'd9642200,
		  ((64'd3850649 << FRAC_BITS) + 64'd4821100) / 64'd9642200,
		  ((64'd1430804 << FRAC_BITS) + 64'd4821100) / 64'd9642200},
		'{((64'd2225045 << FRAC_BITS) + 64'd5000000) / 64'd10000000,
		  ((64'd7168786 << FRAC_BITS) + 64'd5000000) / 64'd10000000,
		  ((64'd606169  << FRAC_BITS) + 64'd5000000) / 64'd10000000},
		'{((64'd139322  << FRAC_BITS) + 64'd4126050) / 64'd8252100,
		  ((64'd971045  << FRAC_BITS) + 64'd4126050) / 64'd8252100,
		  ((64'd7141733 << FRAC_BITS) + 64'd4126050) / 64'd8252100}
	};

	logic [W-1:0]  lut [LUT_DEPTH];
	logic [W-1:0]  lin_s1 [3];
	logic [PW-1:0] prod_s2 [3][3];
	logic [SW-1:0] acc [3];
	logic [TW-1:0] t_s3 [3];

	// gamma table, constant contents
	for (genvar k = 0; k < LUT_DEPTH; k++) begin : g_lut
		localparam longint unsigned V = lin_of(64'(k), FRAC_BITS);
		assign lut[k] = V[W-1:0];
	end

	// stage 1: linearize each channel
	always_ff @(posedge clk) begin
		lin_s1[0] <= lut[red];
		lin_s1[1] <= lut[green];
		lin_s1[2] <= lut[blue];
	end

	// stage 2: nine matrix products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s2[i][j] <= PW'(CF[i][j][W-1:0]) * PW'(lin_s1[j]);
			end
		end
	end

	// row sums with rounding
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = SW'(prod_s2[i][0]) + SW'(prod_s2[i][1]) + SW'(prod_s2[i][2])
				+ (SW'(1) << (FRAC_BITS - 1));
		end
	end

	// stage 3: normalized tristimulus, Q2.F
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t_s3[i] <= acc[i][FRAC_BITS +: TW];
		end
	end

	assign t_x = t_s3[0];
	assign t_y = t_s3[1];
	assign t_z = t_s3[2];

endmodule

// ===== design/s2l_froot.sv =====
module s2l_froot #(
	parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic [FRAC_BITS+1:0] t,
	output logic [FRAC_BITS:0]   f
);
	localparam int TW  = FRAC_BITS + 2;
	localparam int RW  = FRAC_BITS + 1;
	localparam int QW2 = 2 * RW;
	localparam int NS  = FRAC_BITS + 1;
	localparam int NW  = FRAC_BITS + 10;
	localparam int MW  = NW - 11;
	localparam int QW  = FRAC_BITS - 1;
	localparam int KW  = TW + 15;
	localparam int PW2 = NW + MW;
	localparam longint unsigned KNEE = 64'd216 << FRAC_BITS;
	localparam longint unsigned LOFS = (64'd432 << FRAC_BITS) + 64'd1566;
	localparam longint unsigned MREC = (64'd1 << NW) / 64'd3132;

	logic [TW-1:0]  t_s  [1:NS];
	logic [RW-1:0]  r_s  [1:NS];
	logic [QW2-1:0] sq_s [1:NS];

	// bit-serial cube root, one result bit per stage, square kept exact
	for (genvar i = 0; i < NS; i++) begin : g_bit
		localparam int B = FRAC_BITS - i;
		logic [TW-1:0]    t_in;
		logic [RW-1:0]    r_in;
		logic [QW2-1:0]   sq_in;
		logic [RW-1:0]    cand;
		logic [QW2-1:0]   sq_c;
		logic [TW-1:0]    tr;
		logic [TW+RW-1:0] prod;
		logic             take;
		if (i == 0) begin : g_first
			assign t_in  = t;
			assign r_in  = '0;
			assign sq_in = '0;
		end else begin : g_next
			assign t_in  = t_s[i];
			assign r_in  = r_s[i];
			assign sq_in = sq_s[i];
		end
		assign cand = r_in | (RW'(1) << B);
		assign sq_c = sq_in + (QW2'(r_in) << (B + 1)) + (QW2'(1) << (2 * B));
		assign tr   = sq_c[FRAC_BITS +: TW];
		assign prod = (TW + RW)'(tr) * (TW + RW)'(cand);
		assign take = prod[TW+RW-1:FRAC_BITS] <= {1'b0, t_in};
		always_ff @(posedge clk) begin
			t_s[i+1]  <= t_in;
			r_s[i+1]  <= take ? cand : r_in;
			sq_s[i+1] <= take ? sq_c : sq_in;
		end
	end

	// linear segment below the knee: divide by 3132 via reciprocal
	logic [KW-1:0]  kp;
	logic           kn_s1, kn_s2, kn_s3;
	logic [NW-1:0]  n_s1, n_s2;
	logic [QW-1:0]  q0_s2;
	logic [NW-1:0]  qd;
	logic [NW-1:0]  rem;
	logic [RW-1:0]  lin_s3;
	logic [PW2-1:0] qprod;

	assign kp = KW'(t) * KW'(24389);

	always_ff @(posedge clk) begin
		kn_s1 <= kp > KW'(KNEE);
		n_s1  <= NW'(kp + KW'(LOFS));
	end

	assign qprod = PW2'(n_s1) * PW2'(MREC);

	always_ff @(posedge clk) begin
		kn_s2 <= kn_s1;
		n_s2  <= n_s1;
		q0_s2 <= QW'(qprod >> NW);
	end

	// one correction step, estimate is at most one low
	assign qd  = NW'(q0_s2) * NW'(3132);
	assign rem = n_s2 - qd;

	always_ff @(posedge clk) begin
		kn_s3  <= kn_s2;
		lin_s3 <= RW'(q0_s2) + RW'(rem >= NW'(3132));
	end

	// delay the linear result to meet the root chain
	logic [RW-1:0] lin_d_s [4:NS];
	logic          kn_d_s  [4:NS];

	for (genvar d = 4; d <= NS; d++) begin : g_dly
		if (d == 4) begin : g_head
			always_ff @(posedge clk) begin
				lin_d_s[d] <= lin_s3;
				kn_d_s[d]  <= kn_s3;
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				lin_d_s[d] <= lin_d_s[d-1];
				kn_d_s[d]  <= kn_d_s[d-1];
			end
		end
	end

	// pick the segment
	logic [RW-1:0] f_s;

	always_ff @(posedge clk) begin
		f_s <= kn_d_s[NS] ? r_s[NS] : lin_d_s[NS];
	end

	assign f = f_s;

endmodule

// ===== design/s2l_code.sv =====
module s2l_code #(
	parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic [FRAC_BITS:0] fx,
	input  logic [FRAC_BITS:0] fy,
	input  logic [FRAC_BITS:0] fz,
	output logic [7:0]         lightness,
	output logic [7:0]         a_code,
	output logic [7:0]         b_code
);
	localparam int LW = FRAC_BITS + 18;
	localparam int AW = FRAC_BITS + 14;
	localparam int VW = AW - FRAC_BITS;
	localparam int M100 = 41944;

	logic [LW-1:0] lnum_s1;
	logic [AW-1:0] anum_s1, bnum_s1;

	// stage 1: scaled numerators, two's complement
	always_ff @(posedge clk) begin
		lnum_s1 <= LW'(fy) * LW'(29580) - (LW'(4080) << FRAC_BITS);
		anum_s1 <= AW'(fx) * AW'(750) - AW'(fy) * AW'(750) + (AW'(128) << FRAC_BITS);
		bnum_s1 <= AW'(fy) * AW'(255) - AW'(fz) * AW'(255) + (AW'(96) << FRAC_BITS);
	end

	logic [LW-1:0] lsum;
	logic [16:0]   n2;
	logic [AW-1:0] asum, bsum;
	logic [VW-1:0] av, bv;

	assign lsum = lnum_s1 + (LW'(50) << FRAC_BITS);
	assign n2   = lsum[FRAC_BITS +: 17];
	assign asum = anum_s1 + (AW'(1) << (FRAC_BITS - 1));
	assign bsum = bnum_s1 + (AW'(1) << (FRAC_BITS - 1));
	assign av   = asum[FRAC_BITS +: VW];
	assign bv   = bsum[FRAC_BITS +: VW];

	logic        lneg_s2, lsat_s2;
	logic [14:0] ln_s2;
	logic [7:0]  a_s2, b_s2;

	// stage 2: round, clamp chroma codes, flag lightness sign and saturation
	always_ff @(posedge clk) begin
		lneg_s2 <= lnum_s1[LW-1];
		lsat_s2 <= n2 >= 17'd25600;
		ln_s2   <= n2[14:0];
		if (anum_s1[AW-1]) begin
			a_s2 <= 8'd0;
		end else if (av > VW'(255)) begin
			a_s2 <= 8'd255;
		end else begin
			a_s2 <= av[7:0];
		end
		if (bnum_s1[AW-1]) begin
			b_s2 <= 8'd0;
		end else if (bv > VW'(255)) begin
			b_s2 <= 8'd255;
		end else begin
			b_s2 <= bv[7:0];
		end
	end

	logic        lneg_s3, lsat_s3;
	logic [30:0] lprod_s3;
	logic [7:0]  a_s3, b_s3;

	// stage 3: divide by 100 via reciprocal
	always_ff @(posedge clk) begin
		lneg_s3  <= lneg_s2;
		lsat_s3  <= lsat_s2;
		lprod_s3 <= 31'(ln_s2) * 31'(M100);
		a_s3     <= a_s2;
		b_s3     <= b_s2;
	end

	logic [7:0] l_s4, a_s4, b_s4;

	// stage 4: output words
	always_ff @(posedge clk) begin
		if (lneg_s3) begin
			l_s4 <= 8'd0;
		end else if (lsat_s3) begin
			l_s4 <= 8'd255;
		end else begin
			l_s4 <= lprod_s3[22 +: 8];
		end
		a_s4 <= a_s3;
		b_s4 <= b_s3;
	end

	assign lightness = l_s4;
	assign a_code    = a_s4;
	assign b_code    = b_s4;

endmodule

// ===== design/srgb_to_lab8_converter_core.sv =====
// channel | ports                        | handshake
// pixel   | red, green, blue             | taken when start is high and busy is low
// lab     | lightness, a_code, b_code    | valid for one cycle while done is high
//
// one pixel enters every cycle; busy never rises
// each pixel passes through the gamma table and matrix, the bit-serial cube root,
// then scaling and clamping
// reset clears only the valid chain; data registers run free
// the receiver cannot stall, so results are never held
module srgb_to_lab8_converter_core #(
	parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       done,
	output logic [7:0] lightness,
	output logic [7:0] a_code,
	output logic [7:0] b_code
);
	import s2l_pkg::*;

	localparam int LAT = FRAC_BITS + PIPE_FIXED;

	logic [LAT-1:0]     vld_q;
	logic [FRAC_BITS+1:0] t_x, t_y, t_z;
	logic [FRAC_BITS:0]   f_x, f_y, f_z;

	// valid bits follow the words through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LAT-1];

	s2l_linmat #(.FRAC_BITS(FRAC_BITS)) u_linmat (
		.clk   (clk),
		.red   (red),
		.green (green),
		.blue  (blue),
		.t_x   (t_x),
		.t_y   (t_y),
		.t_z   (t_z)
	);

	s2l_froot #(.FRAC_BITS(FRAC_BITS)) u_froot_x (.clk(clk), .t(t_x), .f(f_x));
	s2l_froot #(.FRAC_BITS(FRAC_BITS)) u_froot_y (.clk(clk), .t(t_y), .f(f_y));
	s2l_froot #(.FRAC_BITS(FRAC_BITS)) u_froot_z (.clk(clk), .t(t_z), .f(f_z));

	s2l_code #(.FRAC_BITS(FRAC_BITS)) u_code (
		.clk       (clk),
		.fx        (f_x),
		.fy        (f_y),
		.fz        (f_z),
		.lightness (lightness),
		.a_code    (a_code),
		.b_code    (b_code)
	);

endmodule

// ===== design/s2l_checker.sv =====
module s2l_checker #(
	parameter int FRAC_BITS = s2l_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       done,
	input logic [7:0] lightness,
	input logic [7:0] a_code,
	input logic [7:0] b_code
);
	import s2l_pkg::*;

	localparam int LAT = FRAC_BITS + PIPE_FIXED;

	// the pipeline never pushes back
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every result word comes from a pixel taken a fixed latency earlier
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result word without a matching pixel");

	// black maps to the neutral code
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(red, LAT) == 8'd0 && $past(green, LAT) == 8'd0
			&& $past(blue, LAT) == 8'd0
		|-> lightness == 8'd0 && a_code == 8'd128 && b_code == 8'd96)
		else $error("black pixel gave wrong code");

	// white reaches full lightness
	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(red, LAT) == 8'd255 && $past(green, LAT) == 8'd255
			&& $past(blue, LAT) == 8'd255
		|-> lightness == 8'd255)
		else $error("white pixel short of full lightness");

endmodule

bind srgb_to_lab8_converter_core s2l_checker #(.FRAC_BITS(FRAC_BITS)) u_s2l_chk (.*);

// ===== tb/sv/lab8_checker.sv =====
module lab8_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       done,
	input  logic [7:0] lightness,
	input  logic [7:0] a_code,
	input  logic [7:0] b_code,
	output int         err_cnt,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam int GB = 30;

	typedef struct packed {
		logic [7:0] l;
		logic [7:0] a;
		logic [7:0] b;
	} lab_word_t;

	lab_word_t lab_q[$];
	longint unsigned gamma_tab[256];
	longint unsigned coef_tab[3][3];

	// q^5 with each product truncated to q0.30
	function automatic longint unsigned fifth_pow(input longint unsigned q);
		longint unsigned p;
		p = (q * q) >> GB;
		p = (p * q) >> GB;
		p = (p * q) >> GB;
		p = (p * q) >> GB;
		return p;
	endfunction

	// srgb sample to linear light, q1.16
	function automatic longint unsigned gamma_lin(input longint unsigned c);
		longint unsigned one, u, s, q, cand, l30;
		one = 64'd1 << GB;
		if (c <= 10) begin
			return (((c * 100) << FB) + 164730) / 329460;
		end
		u = (((c * 1000 + 14025) << GB) + 134512) / 269025;
		s = (u * u + (one >> 1)) >> GB;
		q = 0;
		for (int k = GB; k >= 0; k--) begin
			cand = q | (64'd1 << k);
			if (cand <= one && fifth_pow(cand) <= s) begin
				q = cand;
			end
		end
		l30 = (s * q) >> GB;
		return (l30 + (64'd1 << (GB - FB - 1))) >> (GB - FB);
	endfunction

	// lab f: cube root above knee, linear below
	function automatic longint unsigned lab_fn(input longint unsigned t);
		longint unsigned r, cand, cube;
		if (t * 24389 > (64'd216 << FB)) begin
			r = 0;
			for (int k = FB; k >= 0; k--) begin
				cand = r | (64'd1 << k);
				cube = (((cand * cand) >> FB) * cand) >> FB;
				if (cube <= t) begin
					r = cand;
				end
			end
			return r;
		end
		return (t * 24389 + (64'd432 << FB) + 1566) / 3132;
	endfunction

	// divide rounding half away from zero, clamp to 0..255
	function automatic logic [7:0] clamp_code(input longint num, input longint den);
		longint v;
		if (num >= 0) begin
			v = (num + den / 2) / den;
		end else begin
			v = -((-num + den / 2) / den);
		end
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	function automatic lab_word_t lab_of(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		longint unsigned lin[3], acc;
		longint f[3];
		longint one;
		lab_word_t w;
		lin[0] = gamma_tab[r];
		lin[1] = gamma_tab[g];
		lin[2] = gamma_tab[b];
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) begin
				acc += coef_tab[i][j] * lin[j];
			end
			f[i] = longint'(lab_fn((acc + (64'd1 << (FB - 1))) >> FB));
		end
		one = longint'(1) << FB;
		w.l = clamp_code(29580 * f[1] - 4080 * one, 100 * one);
		w.a = clamp_code(750 * (f[0] - f[1]) + 128 * one, one);
		w.b = clamp_code(255 * (f[1] - f[2]) + 96 * one, one);
		return w;
	endfunction

	// tables built once
	initial begin
		longint unsigned num[3][3];
		longint unsigned den[3];
		num = '{'{4360747, 3850649, 1430804}, '{2225045, 7168786, 606169},
			'{139322, 971045, 7141733}};
		den = '{9642200, 10000000, 8252100};
		for (int c = 0; c < 256; c++) begin
			gamma_tab[c] = gamma_lin(c);
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				coef_tab[i][j] = ((num[i][j] << FB) + den[i] / 2) / den[i];
			end
		end
	end

	assign pending = lab_q.size();

	// predict on accepted pixel, compare on done
	always @(posedge clk) begin
		lab_word_t exp_w;
		if (!arst_n) begin
			err_cnt <= 0;
		end else begin
			if (done) begin
				if (lab_q.size() == 0) begin
					err_cnt <= err_cnt + 1;
					if (err_cnt < 10) begin
						$display("unexpected word l=%0d a=%0d b=%0d",
							lightness, a_code, b_code);
					end
				end else begin
					exp_w = lab_q.pop_front();
					if (exp_w.l !== lightness || exp_w.a !== a_code
							|| exp_w.b !== b_code) begin
						err_cnt <= err_cnt + 1;
						if (err_cnt < 10) begin
							$display("mismatch exp l=%0d a=%0d b=%0d got l=%0d a=%0d b=%0d",
								exp_w.l, exp_w.a, exp_w.b, lightness, a_code, b_code);
						end
					end
				end
			end
			if (start && !busy) begin
				lab_q.push_back(lab_of(red, green, blue));
			end
		end
	end

endmodule

// ===== tb/sv/tb_srgb_to_lab8_converter_core.sv =====
module tb_srgb_to_lab8_converter_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 16 + 9;
	localparam int WDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [7:0] red = '0, green = '0, blue = '0;
	logic busy, done;
	logic [7:0] lightness, a_code, b_code;
	int err_cnt, pending;
	int idle_cyc = 0;

	always #6 clk = ~clk;

	srgb_to_lab8_converter_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red(red), .green(green), .blue(blue), .done(done),
		.lightness(lightness), .a_code(a_code), .b_code(b_code)
	);

	lab8_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red(red), .green(green), .blue(blue), .done(done),
		.lightness(lightness), .a_code(a_code), .b_code(b_code),
		.err_cnt(err_cnt), .pending(pending)
	);

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cyc <= 0;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
		if (idle_cyc >= WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// present one pixel and hold it until taken
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		start <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (busy);
	endtask

	task automatic maybe_gap(input bit allow);
		int n;
		if (allow && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 16);
			start <= 1'b0;
			red <= 8'($urandom);
			green <= 8'($urandom);
			blue <= 8'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		logic [7:0] corner[] = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255};
		logic [7:0] lvl;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: black, white, primaries and secondaries, knee of gamma curve
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		for (int i = 0; i < corner.size(); i++) begin
			send_pixel(corner[i], corner[(i + 2) % corner.size()],
				corner[(i + 4) % corner.size()]);
		end
		send_pixel(8'd10, 8'd10, 8'd10);
		send_pixel(8'd11, 8'd11, 8'd11);
		send_pixel(8'd3, 8'd5, 8'd2);
		send_pixel(8'd170, 8'd85, 8'd170);

		// random pixels: greys, near-dark, full range
		for (int i = 0; i < 1300; i++) begin
			maybe_gap(i < 1100);
			case ($urandom_range(0, 3))
				0: begin
					lvl = 8'($urandom_range(0, 255));
					send_pixel(lvl, lvl, lvl);
				end
				1: send_pixel(8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
					8'($urandom_range(0, 20)));
				default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
		end
		start <= 1'b0;

		// drain
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
